/* design/tci_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tci_pkg
// Shared types and constants of the tabulated cdf interpolator.
// ----------------------------------------------------------------------------
package tci_pkg;

  localparam int unsigned GRID_W = 32;
  localparam int unsigned PROB_W = 25;
  localparam int unsigned PUSE_W = 10;

  // probability one in q1.24, and one minus 0.0001 truncated
  localparam logic [PROB_W-1:0] PROB_ONE      = 25'd16777216;
  localparam logic [PROB_W-1:0] PROB_NEAR_ONE = PROB_ONE - 25'd1677;

  localparam logic [PUSE_W-1:0] PUSE_RESET = 10'd500;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_FORWARD = 2'd1,
    CMD_INVERSE = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_INTERP     = 3'd0,
    STAT_CLAMP_LOW  = 3'd1,
    STAT_CLAMP_HIGH = 3'd2,
    STAT_DOMAIN     = 3'd3,
    STAT_WRITTEN    = 3'd4
  } status_e;

  typedef struct packed {
    logic signed [GRID_W-1:0] grid;
    logic [PROB_W-1:0]        prob;
  } entry_t;

  // operands of one interpolation step: |a| * |b| / divisor, then sign
  typedef struct packed {
    logic              start;
    logic              negate;
    logic [31:0]       mul_a;
    logic [PROB_W-1:0] mul_b;
    logic [31:0]       divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [32:0] quotient;
  } div_rsp_t;

endpackage

/* design/tci_table_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tci_table_mem
// Table memory of grid points and probabilities, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module tci_table_mem import tci_pkg::*; #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/tci_muldiv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tci_muldiv
// Registered 32x25 multiply followed by a restoring divide, one quotient
// bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module tci_muldiv import tci_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_MUL,
    D_RUN,
    D_DONE
  } dstate_e;

  localparam logic [4:0] LAST_STEP = 5'd31;

  dstate_e           dstate_q;
  logic [31:0]       a_q;
  logic [PROB_W-1:0] b_q;
  logic [31:0]       den_q;
  logic              neg_q;
  logic [31:0]       rem_q;
  logic [31:0]       quo_q;
  logic [4:0]        cnt_q;

  logic [56:0] prod;
  logic [32:0] rem_sh;
  logic [33:0] trial;
  logic        ge;

  // quotient is known to fit 32 bits, so the top bits start as remainder
  assign prod   = {25'd0, a_q} * {32'd0, b_q};
  assign rem_sh = {rem_q, quo_q[31]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_q};
  assign ge     = ~trial[33];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dstate_q <= D_IDLE;
      a_q      <= '0;
      b_q      <= '0;
      den_q    <= '0;
      neg_q    <= 1'b0;
      rem_q    <= '0;
      quo_q    <= '0;
      cnt_q    <= '0;
    end else begin
      case (dstate_q)
        D_IDLE: begin
          if (req_i.start) begin
            a_q      <= req_i.mul_a;
            b_q      <= req_i.mul_b;
            den_q    <= req_i.divisor;
            neg_q    <= req_i.negate;
            dstate_q <= D_MUL;
          end
        end
        D_MUL: begin
          rem_q    <= {7'd0, prod[56:32]};
          quo_q    <= prod[31:0];
          cnt_q    <= '0;
          dstate_q <= D_RUN;
        end
        D_RUN: begin
          rem_q <= ge ? trial[31:0] : rem_sh[31:0];
          quo_q <= {quo_q[30:0], ge};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == LAST_STEP) begin
            dstate_q <= D_DONE;
          end
        end
        D_DONE: begin
          dstate_q <= D_IDLE;
        end
        default: begin
          dstate_q <= D_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    rsp_o.done     = (dstate_q == D_DONE);
    rsp_o.quotient = neg_q ? $signed(33'd0 - {1'b0, quo_q}) : $signed({1'b0, quo_q});
  end

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> dstate_q == D_IDLE)
    else $error("interpolation step started while divider busy");

endmodule

/* design/tabulated_cdf_interpolator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tabulated_cdf_interpolator_top
// Table of ascending grid points and cumulative probabilities with forward
// (point to probability) and inverse (probability to point) linear lookup.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      in_valid_i / in_stall_o   cmd, entry_*, query_*
//  out       output     out_valid_o / out_stall_i result_value, status
//  cfg       input      cfg_valid_i / cfg_ready_o cfg_points_in_use_i
//
//  write item or unused command: straight from idle to finish
//  lookup clamped at an end: first and last entry fetched, then finish;
//  interpolated: search up to table index k (1 .. points_in_use-1), then divide;
//  the search reads one entry per cycle from the single table read port and
//  the slope divide takes one quotient bit per cycle
//  reset is asynchronous; points_in_use resets to 500, table is undefined
//  until written; one item at a time, a finished result waits in the output
//  register while the next item is taken
// ----------------------------------------------------------------------------
module tabulated_cdf_interpolator_top import tci_pkg::*; #(
  parameter int unsigned MAX_POINTS = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [8:0]         entry_index_i,
  input  logic signed [31:0] entry_point_i,
  input  logic [24:0]        entry_prob_i,
  input  logic signed [31:0] query_point_i,
  input  logic signed [31:0] query_prob_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] result_value_o,
  output logic [2:0]         status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [9:0]         cfg_points_in_use_i
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned NW = $clog2(MAX_POINTS + 1);
  localparam int unsigned CW = (NW > 10) ? NW : 10;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_POINTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH_LAST,
    S_CLAMP,
    S_SCAN,
    S_DIV_WAIT,
    S_FINISH
  } state_e;

  state_e                   state_q;
  logic [PUSE_W-1:0]        puse_q;
  logic                     fwd_q;
  logic                     zero_q;
  logic signed [31:0]       x_q;
  logic [PROB_W-1:0]        q_q;
  logic [AW-1:0]            last_q;
  logic [AW-1:0]            idx_q;
  entry_t                   prev_q;
  logic signed [31:0]       base_q;
  logic signed [31:0]       res_q;
  status_e                  stat_q;
  div_req_t                 div_req_q;
  logic                     out_valid_q;
  logic signed [31:0]       out_value_q;
  status_e                  out_status_q;

  logic                     in_accept;
  logic [CW-1:0]            puse_ext;
  logic [CW-1:0]            n_used;
  logic [CW-1:0]            last_full;
  logic [CW-1:0]            idx_ext;
  logic                     mem_we;
  entry_t                   mem_wdata;
  logic [AW-1:0]            mem_raddr;
  entry_t                   cur;
  logic signed [31:0]       one32;
  logic signed [31:0]       q_map;
  logic                     q_zero;
  logic                     q_oob;
  logic                     hit;
  logic                     scan_done;
  logic signed [32:0]       g_diff;
  logic signed [32:0]       x_diff;
  logic signed [25:0]       p_diff;
  logic [25:0]              p_mag;
  logic [32:0]              g_mag;
  logic [25:0]              q_diff;
  div_req_t                 div_req_d;
  logic signed [31:0]       base_d;
  div_rsp_t                 div_rsp;
  logic signed [33:0]       interp_sum;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // entries in use, saturated to two .. MAX_POINTS
  assign puse_ext  = CW'(puse_q);
  assign n_used    = (puse_ext < CW'(2)) ? CW'(2) : ((puse_ext > MAX_C) ? MAX_C : puse_ext);
  assign last_full = n_used - CW'(1);
  assign idx_ext   = CW'(entry_index_i);

  assign mem_we    = in_accept && (cmd_i == CMD_WRITE) && (idx_ext < MAX_C);
  assign mem_wdata = '{grid: entry_point_i, prob: entry_prob_i};

  // inverse argument: exact one taken as one minus 0.0001
  assign one32  = $signed({7'd0, PROB_ONE});
  assign q_map  = (query_prob_i == one32) ? $signed({7'd0, PROB_NEAR_ONE}) : query_prob_i;
  assign q_zero = (q_map == 32'sd0);
  assign q_oob  = (q_map < 32'sd0) || (q_map > one32);

  always_comb begin
    case (state_q)
      S_FETCH_LAST: mem_raddr = last_q;
      S_CLAMP:      mem_raddr = AW'(1);
      S_SCAN:       mem_raddr = scan_done ? '0 : idx_q + AW'(1);
      default:      mem_raddr = '0;
    endcase
  end

  tci_table_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx_ext[AW-1:0]),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (cur)
  );

  // search hit and interpolation operands from the bracketing entries
  always_comb begin
    if (fwd_q) begin
      hit = (cur.grid >= x_q);
    end else if (zero_q) begin
      hit = (cur.prob != '0);
    end else begin
      hit = (cur.prob >= q_q);
    end
    scan_done = hit || (idx_q == last_q);

    g_diff = {cur.grid[31], cur.grid} - {prev_q.grid[31], prev_q.grid};
    x_diff = {x_q[31], x_q} - {prev_q.grid[31], prev_q.grid};
    p_diff = $signed({1'b0, cur.prob} - {1'b0, prev_q.prob});
    p_mag  = p_diff[25] ? (~p_diff + 26'd1) : p_diff;
    g_mag  = g_diff[32] ? (~g_diff + 33'd1) : g_diff;
    q_diff = {1'b0, q_q} - {1'b0, prev_q.prob};

    div_req_d.start = 1'b1;
    if (fwd_q) begin
      div_req_d.negate  = p_diff[25];
      div_req_d.mul_a   = x_diff[31:0];
      div_req_d.mul_b   = p_mag[24:0];
      div_req_d.divisor = g_diff[31:0];
      base_d            = $signed({7'd0, prev_q.prob});
    end else begin
      div_req_d.negate  = g_diff[32];
      div_req_d.mul_a   = g_mag[31:0];
      div_req_d.mul_b   = q_diff[24:0];
      div_req_d.divisor = {7'd0, p_diff[24:0]};
      base_d            = prev_q.grid;
    end
  end

  tci_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  assign interp_sum = {{2{base_q[31]}}, base_q} + {div_rsp.quotient[32], div_rsp.quotient};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      puse_q <= PUSE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      puse_q <= cfg_points_in_use_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fwd_q        <= 1'b0;
      zero_q       <= 1'b0;
      x_q          <= '0;
      q_q          <= '0;
      last_q       <= '0;
      idx_q        <= '0;
      prev_q       <= '0;
      base_q       <= '0;
      res_q        <= '0;
      stat_q       <= STAT_INTERP;
      div_req_q    <= '0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_status_q <= STAT_INTERP;
    end else begin
      div_req_q.start <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            last_q <= last_full[AW-1:0];
            x_q    <= query_point_i;
            q_q    <= q_map[PROB_W-1:0];
            zero_q <= q_zero;
            res_q  <= '0;
            case (cmd_i)
              CMD_WRITE: begin
                stat_q  <= STAT_WRITTEN;
                state_q <= S_FINISH;
              end
              CMD_FORWARD: begin
                fwd_q   <= 1'b1;
                zero_q  <= 1'b0;
                state_q <= S_FETCH_LAST;
              end
              CMD_INVERSE: begin
                fwd_q <= 1'b0;
                if (q_oob) begin
                  stat_q  <= STAT_DOMAIN;
                  state_q <= S_FINISH;
                end else begin
                  state_q <= S_FETCH_LAST;
                end
              end
              default: begin
                stat_q  <= STAT_DOMAIN;
                state_q <= S_FINISH;
              end
            endcase
          end
        end

        S_FETCH_LAST: begin
          // first entry arrives now, last entry next cycle
          prev_q  <= cur;
          state_q <= S_CLAMP;
        end

        S_CLAMP: begin
          idx_q   <= AW'(1);
          state_q <= S_SCAN;
          if (fwd_q) begin
            if (prev_q.grid >= x_q) begin
              res_q   <= '0;
              stat_q  <= STAT_CLAMP_LOW;
              state_q <= S_FINISH;
            end else if (cur.grid <= x_q) begin
              res_q   <= $signed({7'd0, cur.prob});
              stat_q  <= STAT_CLAMP_HIGH;
              state_q <= S_FINISH;
            end
          end else if (!zero_q) begin
            if (prev_q.prob >= q_q) begin
              res_q   <= prev_q.grid;
              stat_q  <= STAT_CLAMP_LOW;
              state_q <= S_FINISH;
            end else if (q_q > cur.prob) begin
              res_q   <= cur.grid;
              stat_q  <= STAT_CLAMP_HIGH;
              state_q <= S_FINISH;
            end
          end
        end

        S_SCAN: begin
          if (scan_done) begin
            if (zero_q) begin
              // first nonzero probability from index 1 on, else the last entry
              res_q   <= cur.grid;
              stat_q  <= hit ? STAT_CLAMP_LOW : STAT_CLAMP_HIGH;
              state_q <= S_FINISH;
            end else begin
              div_req_q <= div_req_d;
              base_q    <= base_d;
              state_q   <= S_DIV_WAIT;
            end
          end else begin
            prev_q <= cur;
            idx_q  <= idx_q + AW'(1);
          end
        end

        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            res_q   <= interp_sum[31:0];
            stat_q  <= STAT_INTERP;
            state_q <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_value_q  <= res_q;
            out_status_q <= stat_q;
            state_q      <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> (idx_q != '0) && (idx_q <= last_q))
    else $error("table search index outside the entries in use");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV_WAIT)
    else $error("interpolation result with no lookup waiting");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FINISH)
    else $error("result item presented without a finished lookup");

endmodule
